// File: sv/pbsa_pkg.sv
// ----------------------------------------------------------------------------
// pbsa_pkg
// Shared widths, codes and types for the paged bitmap slot allocator.
// ----------------------------------------------------------------------------
package pbsa_pkg;

    localparam int SLOTS_PER_PAGE = 1024;
    localparam int MAX_PAGES      = 8;
    localparam int WORD_W         = 64;
    localparam int WORDS_PER_PAGE = SLOTS_PER_PAGE / WORD_W;
    localparam int PAGE_W         = 3;
    localparam int SLOT_W         = 10;
    localparam int WORD_IDX_W     = 4;
    localparam int BIT_IDX_W      = 6;
    localparam int ADDR_W         = PAGE_W + WORD_IDX_W;
    localparam int MEM_DEPTH      = MAX_PAGES * WORDS_PER_PAGE;
    localparam int PCNT_W         = 4;
    localparam int COUNT_W        = 14;
    localparam int STATUS_W       = 2;
    localparam int UPC_W          = 5;

    localparam logic [PCNT_W-1:0] PAGE_LIMIT_RESET = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [3:0] act_t;

    localparam act_t ACT_NONE        = 4'd0;
    localparam act_t ACT_LATCH       = 4'd1;
    localparam act_t ACT_OPEN_START  = 4'd2;
    localparam act_t ACT_FILL        = 4'd3;
    localparam act_t ACT_OPEN_COMMIT = 4'd4;
    localparam act_t ACT_PICK        = 4'd5;
    localparam act_t ACT_READ        = 4'd6;
    localparam act_t ACT_TAKE        = 4'd7;
    localparam act_t ACT_SET_NOMEM   = 4'd8;
    localparam act_t ACT_FREE_ADDR   = 4'd9;
    localparam act_t ACT_FREE_SET    = 4'd10;
    localparam act_t ACT_SET_BADFREE = 4'd11;
    localparam act_t ACT_EMIT        = 4'd12;

    typedef logic [3:0] cond_t;

    localparam cond_t COND_NEVER        = 4'd0;
    localparam cond_t COND_ALWAYS       = 4'd1;
    localparam cond_t COND_IN_VALID     = 4'd2;
    localparam cond_t COND_IS_FREE      = 4'd3;
    localparam cond_t COND_COUNT_NZ     = 4'd4;
    localparam cond_t COND_CANNOT_OPEN  = 4'd5;
    localparam cond_t COND_FILL_MORE    = 4'd6;
    localparam cond_t COND_NOT_FOUND    = 4'd7;
    localparam cond_t COND_BAD_PAGE     = 4'd8;
    localparam cond_t COND_ALREADY_FREE = 4'd9;
    localparam cond_t COND_OUT_FREE     = 4'd10;

    typedef struct packed {
        act_t act;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic is_free;
        logic count_nz;
        logic cannot_open;
        logic fill_more;
        logic not_found;
        logic bad_page;
        logic already_free;
        logic out_free;
    } flags_t;

    typedef struct packed {
        act_t             act;
        cond_t            cond;
        logic [UPC_W-1:0] target;
        logic             hold;
    } uword_t;

endpackage

// File: sv/pbsa_req_if.sv
// ----------------------------------------------------------------------------
// pbsa_req_if
// Request channel: allocate or free one slot.
// ----------------------------------------------------------------------------
interface pbsa_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] free_page;
    logic [9:0] free_slot;

    modport source (output valid, output op, output free_page, output free_slot,
                    input ready);
    modport sink   (input valid, input op, input free_page, input free_slot,
                    output ready);
endinterface

// File: sv/pbsa_rsp_if.sv
// ----------------------------------------------------------------------------
// pbsa_rsp_if
// Result channel: status, granted slot and free total for one request.
// ----------------------------------------------------------------------------
interface pbsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  granted_page;
    logic [9:0]  granted_slot;
    logic        opened_page;
    logic [13:0] free_total;

    modport source (output valid, output status, output granted_page,
                    output granted_slot, output opened_page, output free_total,
                    input ready);
    modport sink   (input valid, input status, input granted_page,
                    input granted_slot, input opened_page, input free_total,
                    output ready);
endinterface

// File: sv/pbsa_sequencer.sv
// ----------------------------------------------------------------------------
// pbsa_sequencer
// Step counter and control store; one control word per step with a
// conditional jump, a hold bit and a datapath action.
// ----------------------------------------------------------------------------
module pbsa_sequencer
(
    input  logic            clk,
    input  logic            rst_n,
    input  pbsa_pkg::flags_t flags,
    output pbsa_pkg::ctrl_t  ctrl
);
    import pbsa_pkg::*;

    localparam logic [UPC_W-1:0] ST_WAIT      = 5'd0;
    localparam logic [UPC_W-1:0] ST_DISPATCH  = 5'd1;
    localparam logic [UPC_W-1:0] ST_ALLOC     = 5'd2;
    localparam logic [UPC_W-1:0] ST_LIMIT     = 5'd3;
    localparam logic [UPC_W-1:0] ST_OPEN_INIT = 5'd4;
    localparam logic [UPC_W-1:0] ST_OPEN_FILL = 5'd5;
    localparam logic [UPC_W-1:0] ST_OPEN_DONE = 5'd6;
    localparam logic [UPC_W-1:0] ST_PICK      = 5'd7;
    localparam logic [UPC_W-1:0] ST_READ      = 5'd8;
    localparam logic [UPC_W-1:0] ST_TAKE      = 5'd9;
    localparam logic [UPC_W-1:0] ST_NOMEM     = 5'd10;
    localparam logic [UPC_W-1:0] ST_FREE_ADDR = 5'd11;
    localparam logic [UPC_W-1:0] ST_FREE_READ = 5'd12;
    localparam logic [UPC_W-1:0] ST_FREE_TEST = 5'd13;
    localparam logic [UPC_W-1:0] ST_FREE_SET  = 5'd14;
    localparam logic [UPC_W-1:0] ST_BADFREE   = 5'd15;
    localparam logic [UPC_W-1:0] ST_FINISH    = 5'd16;

    function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
        uword_t w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, target: ST_WAIT, hold: 1'b0};
        case (pc)
            ST_WAIT:      w = '{ACT_LATCH,       COND_IN_VALID,     ST_DISPATCH,  1'b1};
            ST_DISPATCH:  w = '{ACT_NONE,        COND_IS_FREE,      ST_FREE_ADDR, 1'b0};
            ST_ALLOC:     w = '{ACT_NONE,        COND_COUNT_NZ,     ST_PICK,      1'b0};
            ST_LIMIT:     w = '{ACT_NONE,        COND_CANNOT_OPEN,  ST_NOMEM,     1'b0};
            ST_OPEN_INIT: w = '{ACT_OPEN_START,  COND_NEVER,        ST_WAIT,      1'b0};
            ST_OPEN_FILL: w = '{ACT_FILL,        COND_FILL_MORE,    ST_OPEN_FILL, 1'b0};
            ST_OPEN_DONE: w = '{ACT_OPEN_COMMIT, COND_NEVER,        ST_WAIT,      1'b0};
            ST_PICK:      w = '{ACT_PICK,        COND_NOT_FOUND,    ST_NOMEM,     1'b0};
            ST_READ:      w = '{ACT_READ,        COND_NEVER,        ST_WAIT,      1'b0};
            ST_TAKE:      w = '{ACT_TAKE,        COND_ALWAYS,       ST_FINISH,    1'b0};
            ST_NOMEM:     w = '{ACT_SET_NOMEM,   COND_ALWAYS,       ST_FINISH,    1'b0};
            ST_FREE_ADDR: w = '{ACT_FREE_ADDR,   COND_BAD_PAGE,     ST_BADFREE,   1'b0};
            ST_FREE_READ: w = '{ACT_READ,        COND_NEVER,        ST_WAIT,      1'b0};
            ST_FREE_TEST: w = '{ACT_NONE,        COND_ALREADY_FREE, ST_BADFREE,   1'b0};
            ST_FREE_SET:  w = '{ACT_FREE_SET,    COND_ALWAYS,       ST_FINISH,    1'b0};
            ST_BADFREE:   w = '{ACT_SET_BADFREE, COND_NEVER,        ST_WAIT,      1'b0};
            ST_FINISH:    w = '{ACT_EMIT,        COND_OUT_FREE,     ST_WAIT,      1'b1};
            default:      w = '{ACT_NONE,        COND_ALWAYS,       ST_WAIT,      1'b0};
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uw;
    logic             taken;

    always_comb
    begin
        uw = ucode(upc_reg);
        case (uw.cond)
            COND_NEVER:        taken = 1'b0;
            COND_ALWAYS:       taken = 1'b1;
            COND_IN_VALID:     taken = flags.in_valid;
            COND_IS_FREE:      taken = flags.is_free;
            COND_COUNT_NZ:     taken = flags.count_nz;
            COND_CANNOT_OPEN:  taken = flags.cannot_open;
            COND_FILL_MORE:    taken = flags.fill_more;
            COND_NOT_FOUND:    taken = flags.not_found;
            COND_BAD_PAGE:     taken = flags.bad_page;
            COND_ALREADY_FREE: taken = flags.already_free;
            COND_OUT_FREE:     taken = flags.out_free;
            default:           taken = 1'b0;
        endcase
        if (taken)
        begin
            upc_next = uw.target;
        end
        else if (uw.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
        ctrl.act = uw.act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: sv/pbsa_datapath.sv
// ----------------------------------------------------------------------------
// pbsa_datapath
// Bitmap memory, per-word nonempty summary, counters and result registers,
// driven one action per cycle by the sequencer.
// ----------------------------------------------------------------------------
module pbsa_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pbsa_pkg::ctrl_t                 ctrl,
    output pbsa_pkg::flags_t                flags,
    input  logic                            cfg_we,
    input  logic [pbsa_pkg::PCNT_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_op,
    input  logic [pbsa_pkg::PAGE_W-1:0]     in_free_page,
    input  logic [pbsa_pkg::SLOT_W-1:0]     in_free_slot,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [pbsa_pkg::STATUS_W-1:0]   out_status,
    output logic [pbsa_pkg::PAGE_W-1:0]     out_granted_page,
    output logic [pbsa_pkg::SLOT_W-1:0]     out_granted_slot,
    output logic                            out_opened_page,
    output logic [pbsa_pkg::COUNT_W-1:0]    out_free_total
);
    import pbsa_pkg::*;

    // Bitmap store: one word per (page, word index); bit set means slot free
    logic [WORD_W-1:0] mem [0:MEM_DEPTH-1];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [WORD_W-1:0] mem_wdata;

    // Summary bit set means the word holds at least one free slot
    logic [MAX_PAGES-1:0][WORDS_PER_PAGE-1:0] summary_reg, summary_next;

    logic [PCNT_W-1:0]   page_limit_reg, page_limit_next;
    logic [PCNT_W-1:0]   pages_open_reg, pages_open_next;
    logic [COUNT_W-1:0]  free_count_reg, free_count_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                op_reg, op_next;
    logic [PAGE_W-1:0]   fpage_reg, fpage_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PAGE_W-1:0]   gpage_reg, gpage_next;
    logic [SLOT_W-1:0]   gslot_reg, gslot_next;
    logic                opened_reg, opened_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PAGE_W-1:0]   out_gpage_reg, out_gpage_next;
    logic [SLOT_W-1:0]   out_gslot_reg, out_gslot_next;
    logic                out_opened_reg, out_opened_next;
    logic [COUNT_W-1:0]  out_total_reg, out_total_next;

    logic [PAGE_W-1:0]     pick_page;
    logic                  pick_found;
    logic [WORD_IDX_W-1:0] pick_word;
    logic [BIT_IDX_W-1:0]  take_bit;
    logic [WORD_W-1:0]     take_word;
    logic [WORD_W-1:0]     set_word;
    logic                  out_free;

    // Newest open page with any free word, then its lowest such word
    always_comb
    begin
        pick_page  = '0;
        pick_found = 1'b0;
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            if ((PCNT_W'(p) < pages_open_reg) && (|summary_reg[p]))
            begin
                pick_page  = PAGE_W'(p);
                pick_found = 1'b1;
            end
        end
        pick_word = '0;
        for (int w = WORDS_PER_PAGE - 1; w >= 0; w--)
        begin
            if (summary_reg[pick_page][w])
            begin
                pick_word = WORD_IDX_W'(w);
            end
        end
    end

    // Lowest free bit of the word read back
    always_comb
    begin
        take_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (rd_data_reg[b])
            begin
                take_bit = BIT_IDX_W'(b);
            end
        end
        take_word = rd_data_reg & ~(WORD_W'(1) << take_bit);
        set_word  = rd_data_reg | (WORD_W'(1) << fslot_reg[BIT_IDX_W-1:0]);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        flags.in_valid     = in_valid;
        flags.is_free      = (op_reg == OP_FREE);
        flags.count_nz     = (free_count_reg != '0);
        flags.cannot_open  = (pages_open_reg >= page_limit_reg) ||
                             (pages_open_reg >= PCNT_W'(MAX_PAGES));
        flags.fill_more    = (addr_reg[WORD_IDX_W-1:0] != WORD_IDX_W'(WORDS_PER_PAGE - 1));
        flags.not_found    = !pick_found;
        flags.bad_page     = ({1'b0, fpage_reg} >= pages_open_reg);
        flags.already_free = rd_data_reg[fslot_reg[BIT_IDX_W-1:0]];
        flags.out_free     = out_free;
    end

    always_comb
    begin
        page_limit_next = page_limit_reg;
        pages_open_next = pages_open_reg;
        free_count_next = free_count_reg;
        summary_next    = summary_reg;
        addr_next       = addr_reg;
        op_next         = op_reg;
        fpage_next      = fpage_reg;
        fslot_next      = fslot_reg;
        status_next     = status_reg;
        gpage_next      = gpage_reg;
        gslot_next      = gslot_reg;
        opened_next     = opened_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_gpage_next  = out_gpage_reg;
        out_gslot_next  = out_gslot_reg;
        out_opened_next = out_opened_reg;
        out_total_next  = out_total_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = take_word;

        if (cfg_we)
        begin
            page_limit_next = cfg_wdata;
        end

        // Drop the held result once the sink takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.act)
            ACT_LATCH:
            begin
                if (in_valid)
                begin
                    op_next     = in_op;
                    fpage_next  = in_free_page;
                    fslot_next  = in_free_slot;
                    status_next = STATUS_OK;
                    gpage_next  = '0;
                    gslot_next  = '0;
                    opened_next = 1'b0;
                end
            end
            ACT_OPEN_START:
            begin
                addr_next   = {pages_open_reg[PAGE_W-1:0], {WORD_IDX_W{1'b0}}};
                opened_next = 1'b1;
                summary_next[pages_open_reg[PAGE_W-1:0]] = '1;
            end
            ACT_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = '1;
                addr_next = {addr_reg[ADDR_W-1:WORD_IDX_W],
                             addr_reg[WORD_IDX_W-1:0] + 1'b1};
            end
            ACT_OPEN_COMMIT:
            begin
                pages_open_next = pages_open_reg + 1'b1;
                free_count_next = free_count_reg + COUNT_W'(SLOTS_PER_PAGE);
            end
            ACT_PICK:
            begin
                addr_next = {pick_page, pick_word};
            end
            ACT_READ:
            begin
                mem_re = 1'b1;
            end
            ACT_TAKE:
            begin
                mem_we          = 1'b1;
                mem_wdata       = take_word;
                free_count_next = free_count_reg - 1'b1;
                gpage_next      = addr_reg[ADDR_W-1:WORD_IDX_W];
                gslot_next      = {addr_reg[WORD_IDX_W-1:0], take_bit};
                if (take_word == '0)
                begin
                    summary_next[addr_reg[ADDR_W-1:WORD_IDX_W]]
                                [addr_reg[WORD_IDX_W-1:0]] = 1'b0;
                end
            end
            ACT_SET_NOMEM:
            begin
                status_next = STATUS_NOMEM;
                gpage_next  = '0;
                gslot_next  = '0;
                opened_next = 1'b0;
            end
            ACT_FREE_ADDR:
            begin
                addr_next = {fpage_reg, fslot_reg[SLOT_W-1:BIT_IDX_W]};
            end
            ACT_FREE_SET:
            begin
                mem_we          = 1'b1;
                mem_wdata       = set_word;
                free_count_next = free_count_reg + 1'b1;
                summary_next[addr_reg[ADDR_W-1:WORD_IDX_W]]
                            [addr_reg[WORD_IDX_W-1:0]] = 1'b1;
            end
            ACT_SET_BADFREE:
            begin
                status_next = STATUS_BAD_FREE;
            end
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_gpage_next  = gpage_reg;
                    out_gslot_next  = gslot_reg;
                    out_opened_next = opened_reg;
                    out_total_next  = free_count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        else if (mem_re)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= PAGE_LIMIT_RESET;
            pages_open_reg <= '0;
            free_count_reg <= '0;
            summary_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            page_limit_reg <= page_limit_next;
            pages_open_reg <= pages_open_next;
            free_count_reg <= free_count_next;
            summary_reg    <= summary_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        op_reg         <= op_next;
        fpage_reg      <= fpage_next;
        fslot_reg      <= fslot_next;
        status_reg     <= status_next;
        gpage_reg      <= gpage_next;
        gslot_reg      <= gslot_next;
        opened_reg     <= opened_next;
        out_status_reg <= out_status_next;
        out_gpage_reg  <= out_gpage_next;
        out_gslot_reg  <= out_gslot_next;
        out_opened_reg <= out_opened_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_granted_page = out_gpage_reg;
    assign out_granted_slot = out_gslot_reg;
    assign out_opened_page  = out_opened_reg;
    assign out_free_total   = out_total_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= {pages_open_reg, {SLOT_W{1'b0}}})
        else $error("free count exceeds capacity of open pages");

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_open_reg <= PCNT_W'(MAX_PAGES))
        else $error("too many pages open");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_TAKE) |-> (rd_data_reg != '0))
        else $error("summary pointed at a full word");

    a_free_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_FREE_SET) |-> (free_count_reg < {pages_open_reg, {SLOT_W{1'b0}}}))
        else $error("free accepted with every slot already free");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_EMIT && out_free) |=> (out_valid_reg && out_total_reg == $past(free_count_reg)))
        else $error("result not loaded on emit");
`endif

endmodule

// File: sv/paged_bitmap_slot_allocator.sv
// Opening a page fills the new page's 16 bitmap words through the single memory port
// before the allocation goes on; the next item is taken while a result waits.
// Reset clears the page count, free count and word summary, sets page_limit to 8;
// the bitmap memory is not cleared, each page is written in full when it opens.
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator
// Paged bitmap slot allocator with find-first-free, run by a microcoded
// sequencer over a bitmap memory datapath.
// ----------------------------------------------------------------------------
module paged_bitmap_slot_allocator
(
    input  logic                        clk,
    input  logic                        rst_n,
    pbsa_req_if.sink                    req,
    pbsa_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic [pbsa_pkg::PCNT_W-1:0] cfg_wdata
);
    import pbsa_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    assign req.ready = (ctrl.act == ACT_LATCH);

    pbsa_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pbsa_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .flags            (flags),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (req.valid),
        .in_op            (req.op),
        .in_free_page     (req.free_page),
        .in_free_slot     (req.free_slot),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_status       (rsp.status),
        .out_granted_page (rsp.granted_page),
        .out_granted_slot (rsp.granted_slot),
        .out_opened_page  (rsp.opened_page),
        .out_free_total   (rsp.free_total)
    );

endmodule
